// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled during reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: hdl/sarq_pkg.sv
// Package for the report-alternating transmit queue.
// Types and constants shared by all modules; no dependencies.
package sarq_pkg;
  localparam int QueueDepth = 16;
  localparam int IdxW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [7:0] FullBlockLen = 8'd23;
  localparam logic [7:0] StaleLimit = 8'd5;
  localparam logic [7:0] ReuseMax = 8'd255;
  localparam int FifoDepth = 2;

  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_SACCH = 2'd1;
  localparam logic [1:0] OP_TCH = 2'd2;

  localparam logic [1:0] ORIG_QUEUE = 2'd0;
  localparam logic [1:0] ORIG_CACHE = 2'd1;
  localparam logic [1:0] ORIG_DEFAULT = 2'd2;
  localparam logic [1:0] ORIG_NONE = 2'd3;

  localparam logic CFG_RR_PD = 1'b0;
  localparam logic CFG_MR_TYPE = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] entry_tag;
    logic [3:0] proto_disc;
    logic [7:0] msg_kind;
    logic [7:0] payload_len;
    logic       want_full_block;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       found;
    logic [7:0] out_tag;
    logic [1:0] origin_code;
    logic       sent_report;
    logic [7:0] reuse_count;
    logic       stale_report;
  } out_item_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] tag;
    logic       is_report;
    logic       is_full;
    logic       want_full;
  } cmd_t;
endpackage

// File: hdl/sacch_report_alternating_tx_queue_top.sv
// Top level of the report-alternating transmit queue.
// Depends on sarq_pkg, sarq_front and sarq_back.
//
// Usage: items enter on in_valid/in_ready carrying an opcode (enqueue,
// SACCH dequeue or TCH dequeue) and enqueue attributes. Every item yields
// exactly one result item on out_valid/out_ready.
// The front stage classifies an enqueue as a measurement report using the
// two configuration registers and pushes a command into a two-entry FIFO,
// so new items are taken while the back end is busy or stalled.
// The back end scans its sixteen-entry queue one entry per cycle and closes
// the gap left by a removed entry one entry per cycle; a dequeue goes from
// the scan state, through the shift state when it removes an entry, to the
// output state, an enqueue straight from idle to the output state.
// The single scan-and-shift loop in the back end sets the item rate.
// Reset clears the queue count, the alternation flag, the report cache and
// the reuse counter, and restores the register defaults (6 and 21).
// If the receiver holds out_ready low, the result waits in the output
// register, the back end stops, and the FIFO fills until in_ready drops.
// Configuration writes via cfg_we, cfg_index and cfg_data take effect at once.
module sacch_report_alternating_tx_queue_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sarq_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sarq_pkg::out_item_t  out_item
);
  logic cmd_valid, cmd_ready;
  sarq_pkg::cmd_t cmd;

  sarq_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready, .in_item,
    .cmd_valid, .cmd_ready, .cmd
  );

  sarq_back u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready, .out_item
  );
endmodule

// File: hdl/sarq_front.sv
// Front end: accepts items, classifies enqueues and feeds a short command FIFO.
// Depends on sarq_pkg.
module sarq_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sarq_pkg::in_item_t   in_item,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output sarq_pkg::cmd_t       cmd
);
  localparam int PW = $clog2(sarq_pkg::FifoDepth);
  logic [3:0] rr_pd;
  logic [7:0] mr_type;
  sarq_pkg::cmd_t fifo [sarq_pkg::FifoDepth];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0] fill;
  sarq_pkg::cmd_t new_cmd;
  logic push, pop;

  assign in_ready = (fill != PW'(0) + (PW+1)'(sarq_pkg::FifoDepth));
  assign cmd_valid = (fill != '0);
  assign cmd = fifo[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = cmd_valid && cmd_ready;

  always_comb begin
    new_cmd.opcode = in_item.opcode;
    new_cmd.tag = in_item.entry_tag;
    new_cmd.is_report = (in_item.proto_disc == rr_pd) && (in_item.msg_kind == mr_type);
    new_cmd.is_full = (in_item.payload_len == sarq_pkg::FullBlockLen);
    new_cmd.want_full = in_item.want_full_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rr_pd <= 4'd6;
      mr_type <= 8'd21;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sarq_pkg::CFG_RR_PD: rr_pd <= cfg_data[3:0];
          sarq_pkg::CFG_MR_TYPE: mr_type <= cfg_data;
          default: ;
        endcase
      end
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      case ({push, pop})
        2'b10: fill <= fill + (PW+1)'(1);
        2'b01: fill <= fill - (PW+1)'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= new_cmd;
  end
endmodule

// File: hdl/sarq_back.sv
// Back end: holds the frame queue, scans it one entry a cycle and compacts it.
// Depends on sarq_pkg.
module sarq_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  sarq_pkg::cmd_t       cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sarq_pkg::out_item_t  out_item
);
  localparam int IW = sarq_pkg::IdxW;
  localparam int CW = sarq_pkg::CntW;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_OUT} state_t;
  state_t state;

  logic [7:0] q_tag [sarq_pkg::QueueDepth];
  logic       q_rep [sarq_pkg::QueueDepth];
  logic       q_full [sarq_pkg::QueueDepth];
  logic [CW-1:0] count;
  logic last_rep, cache_ok;
  logic [7:0] reuse;
  sarq_pkg::cmd_t cur;
  logic [CW-1:0] idx;
  logic have_mr, have_nmr, hit;
  logic [IW-1:0] pos_mr, pos_nmr, pick;
  sarq_pkg::out_item_t res;
  logic [7:0] reuse_inc;

  assign cmd_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_item = res;
  assign reuse_inc = (reuse != sarq_pkg::ReuseMax) ? reuse + 8'd1 : reuse;

  // Store writes: enqueue and one compaction step per cycle.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid && cmd.opcode == sarq_pkg::OP_ENQ &&
        count != CW'(sarq_pkg::QueueDepth)) begin
      q_tag[count[IW-1:0]] <= cmd.tag;
      q_rep[count[IW-1:0]] <= cmd.is_report;
      q_full[count[IW-1:0]] <= cmd.is_full;
    end else if (state == S_SHIFT && (CW'(pick) + CW'(1)) < count) begin
      q_tag[pick] <= q_tag[pick + IW'(1)];
      q_rep[pick] <= q_rep[pick + IW'(1)];
      q_full[pick] <= q_full[pick + IW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      last_rep <= 1'b0;
      cache_ok <= 1'b0;
      reuse <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            idx <= '0;
            have_mr <= 1'b0;
            have_nmr <= 1'b0;
            hit <= 1'b0;
            res <= '{accepted: (cmd.opcode == sarq_pkg::OP_ENQ) &&
                               (count != CW'(sarq_pkg::QueueDepth)),
                     found: 1'b0, out_tag: 8'h00,
                     origin_code: sarq_pkg::ORIG_NONE, sent_report: 1'b0,
                     reuse_count: 8'h00, stale_report: 1'b0};
            case (cmd.opcode)
              sarq_pkg::OP_ENQ: begin
                if (count != CW'(sarq_pkg::QueueDepth)) begin
                  count <= count + CW'(1);
                end
                state <= S_OUT;
              end
              sarq_pkg::OP_SACCH, sarq_pkg::OP_TCH: state <= S_SCAN;
              default: state <= S_OUT;
            endcase
          end
        end
        S_SCAN: begin
          if (idx < count && !hit) begin
            if (cur.opcode == sarq_pkg::OP_TCH) begin
              if (q_full[idx[IW-1:0]] == cur.want_full) begin
                hit <= 1'b1;
                pick <= idx[IW-1:0];
              end
            end else if (q_rep[idx[IW-1:0]]) begin
              if (!have_mr) begin
                have_mr <= 1'b1;
                pos_mr <= idx[IW-1:0];
              end
            end else if (!have_nmr) begin
              have_nmr <= 1'b1;
              pos_nmr <= idx[IW-1:0];
            end
            idx <= idx + CW'(1);
          end else if (cur.opcode == sarq_pkg::OP_TCH) begin
            if (hit) begin
              res.found <= 1'b1;
              res.out_tag <= q_tag[pick];
              res.origin_code <= sarq_pkg::ORIG_QUEUE;
              state <= S_SHIFT;
            end else begin
              state <= S_OUT;
            end
          end else begin
            res.found <= 1'b1;
            if (!last_rep && have_mr || last_rep && (have_mr || have_nmr)) begin
              if (!last_rep || !have_nmr) begin
                pick <= pos_mr;
                res.out_tag <= q_tag[pos_mr];
                res.sent_report <= 1'b1;
                res.reuse_count <= 8'h00;
                cache_ok <= 1'b1;
                reuse <= 8'h00;
                last_rep <= 1'b1;
              end else begin
                pick <= pos_nmr;
                res.out_tag <= q_tag[pos_nmr];
                res.reuse_count <= reuse;
                res.stale_report <= reuse > sarq_pkg::StaleLimit;
                last_rep <= 1'b0;
              end
              res.origin_code <= sarq_pkg::ORIG_QUEUE;
              state <= S_SHIFT;
            end else begin
              res.origin_code <= cache_ok ? sarq_pkg::ORIG_CACHE : sarq_pkg::ORIG_DEFAULT;
              res.sent_report <= 1'b1;
              res.reuse_count <= reuse_inc;
              res.stale_report <= reuse_inc > sarq_pkg::StaleLimit;
              cache_ok <= 1'b1;
              reuse <= reuse_inc;
              last_rep <= 1'b1;
              state <= S_OUT;
            end
          end
        end
        S_SHIFT: begin
          if ((CW'(pick) + CW'(1)) < count) begin
            pick <= pick + IW'(1);
          end else begin
            count <= count - CW'(1);
            state <= S_OUT;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/sarq_checker.sv
// Port-level checker for the transmit queue, bound to the top level.
// Depends on sarq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sarq_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input sarq_pkg::out_item_t out_item
);
  `CHK_IMPLY(a_stale, clk, rst, out_valid, out_item.stale_report == (out_item.reuse_count > sarq_pkg::StaleLimit) || !out_item.found, "stale flag mismatch")
  `CHK_IMPLY(a_orig, clk, rst, out_valid && !out_item.found, out_item.origin_code == sarq_pkg::ORIG_NONE, "origin without frame")
  `CHK_IMPLY(a_fallback, clk, rst, out_valid && (out_item.origin_code == sarq_pkg::ORIG_CACHE || out_item.origin_code == sarq_pkg::ORIG_DEFAULT), out_item.sent_report && out_item.reuse_count != 8'h00, "fallback fields")
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item), "result dropped")
endmodule

bind sacch_report_alternating_tx_queue_top sarq_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .out_item
);

// File: tb/tb.sv
// Testbench for the report-alternating transmit queue top level.
// Depends on sarq_pkg and sacch_report_alternating_tx_queue_top; drives items,
// predicts each result with a local queue model and checks every result field.
`timescale 1ns / 1ps

module tb;
  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic                cfg_index;
  logic [7:0]          cfg_data;
  logic                in_valid;
  logic                in_ready;
  sarq_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  sarq_pkg::out_item_t out_item;

  sacch_report_alternating_tx_queue_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  // Shadow state of the queue, used to predict each result.
  logic [7:0] q_tag [sarq_pkg::QueueDepth];
  logic       q_rep [sarq_pkg::QueueDepth];
  logic       q_full [sarq_pkg::QueueDepth];
  int         q_cnt;
  logic       prev_report;
  logic       cache_valid;
  logic [7:0] reuse;
  logic [3:0] rr_pd;
  logic [7:0] mr_type;

  sarq_pkg::out_item_t pending_results[$];
  int         errors;
  int         results_seen;
  int         items_sent;
  int         fallbacks_seen;
  int         rejects_seen;
  longint     cycle_count;

  // Pacing knobs for both sides of the handshake.
  bit         steady;       // when set, neither side idles
  bit         hold_results; // receiver holds off out_ready for a long stretch
  int         hold_cycles;

  localparam longint CycleLimit = 400000;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // Remove the entry at pos and close the gap, keeping order.
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < q_cnt; i++) begin
      q_tag[i] = q_tag[i + 1];
      q_rep[i] = q_rep[i + 1];
      q_full[i] = q_full[i + 1];
    end
    q_cnt--;
  endfunction

  // Work out the result of one item and advance the shadow state.
  function automatic sarq_pkg::out_item_t predict_result(sarq_pkg::in_item_t it);
    sarq_pkg::out_item_t r;
    int pos_rep, pos_other, pick;
    r = '0;
    r.origin_code = sarq_pkg::ORIG_NONE;
    pos_rep = -1;
    pos_other = -1;
    pick = -1;
    case (it.opcode)
      sarq_pkg::OP_ENQ: begin
        if (q_cnt < sarq_pkg::QueueDepth) begin
          q_tag[q_cnt] = it.entry_tag;
          q_rep[q_cnt] = (it.proto_disc == rr_pd) && (it.msg_kind == mr_type);
          q_full[q_cnt] = (it.payload_len == sarq_pkg::FullBlockLen);
          q_cnt++;
          r.accepted = 1'b1;
        end else begin
          rejects_seen++;
        end
      end
      sarq_pkg::OP_SACCH: begin
        for (int i = 0; i < q_cnt; i++) begin
          if (q_rep[i] && pos_rep < 0) pos_rep = i;
          if (!q_rep[i] && pos_other < 0) pos_other = i;
        end
        // A report is due after a non-report; otherwise prefer a non-report.
        if (!prev_report) pick = pos_rep;
        else pick = (pos_other >= 0) ? pos_other : pos_rep;
        r.found = 1'b1;
        if (pick >= 0) begin
          r.out_tag = q_tag[pick];
          r.origin_code = sarq_pkg::ORIG_QUEUE;
          r.sent_report = q_rep[pick];
          if (q_rep[pick]) begin
            cache_valid = 1'b1;
            reuse = '0;
          end
          prev_report = q_rep[pick];
          drop_entry(pick);
        end else begin
          fallbacks_seen++;
          r.origin_code = cache_valid ? sarq_pkg::ORIG_CACHE : sarq_pkg::ORIG_DEFAULT;
          cache_valid = 1'b1;
          if (reuse != sarq_pkg::ReuseMax) reuse++;
          r.sent_report = 1'b1;
          prev_report = 1'b1;
        end
        r.reuse_count = reuse;
        r.stale_report = (reuse > sarq_pkg::StaleLimit);
      end
      sarq_pkg::OP_TCH: begin
        for (int i = 0; i < q_cnt; i++) begin
          if (q_full[i] == it.want_full_block) begin
            r.found = 1'b1;
            r.out_tag = q_tag[i];
            r.origin_code = sarq_pkg::ORIG_QUEUE;
            drop_entry(i);
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one item; the expectation is queued at the accepting edge.
  // Valid stays high into the next item unless the sender idles first.
  task automatic send_item(sarq_pkg::in_item_t it);
    if (!steady && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < 6) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_result(it));
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver pacing: random idling, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_results) begin
      out_ready <= 1'b0;
      hold_cycles++;
      if (hold_cycles >= 300) hold_results <= 1'b0;
    end else begin
      out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 6);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    sarq_pkg::out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_item.accepted !== exp_r.accepted) begin
          $error("accepted: expected %0d actual %0d", exp_r.accepted, out_item.accepted);
          errors++;
        end
        if (out_item.found !== exp_r.found) begin
          $error("found: expected %0d actual %0d", exp_r.found, out_item.found);
          errors++;
        end
        if (out_item.out_tag !== exp_r.out_tag) begin
          $error("out_tag: expected %0d actual %0d", exp_r.out_tag, out_item.out_tag);
          errors++;
        end
        if (out_item.origin_code !== exp_r.origin_code) begin
          $error("origin_code: expected %0d actual %0d",
                 exp_r.origin_code, out_item.origin_code);
          errors++;
        end
        if (out_item.sent_report !== exp_r.sent_report) begin
          $error("sent_report: expected %0d actual %0d",
                 exp_r.sent_report, out_item.sent_report);
          errors++;
        end
        if (out_item.reuse_count !== exp_r.reuse_count) begin
          $error("reuse_count: expected %0d actual %0d",
                 exp_r.reuse_count, out_item.reuse_count);
          errors++;
        end
        if (out_item.stale_report !== exp_r.stale_report) begin
          $error("stale_report: expected %0d actual %0d",
                 exp_r.stale_report, out_item.stale_report);
          errors++;
        end
      end
    end
  end

  function automatic sarq_pkg::in_item_t make_item(logic [1:0] op, logic [7:0] tag,
                                                   logic [3:0] pd, logic [7:0] mt,
                                                   logic [7:0] len, logic want);
    sarq_pkg::in_item_t it;
    it.opcode = op;
    it.entry_tag = tag;
    it.proto_disc = pd;
    it.msg_kind = mt;
    it.payload_len = len;
    it.want_full_block = want;
    return it;
  endfunction

  // Wait until every expected result has arrived, then let the back end settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == sarq_pkg::CFG_RR_PD) rr_pd = val[3:0];
    else mr_type = val;
  endtask

  // A random item: enqueues of reports and non-reports under the current registers,
  // full blocks and speech, with dequeues and the unused opcode mixed in so the queue keeps cycling.
  function automatic sarq_pkg::in_item_t rand_item();
    sarq_pkg::in_item_t it;
    int sel;
    it = make_item(sarq_pkg::OP_ENQ, 8'($urandom()), 4'($urandom()), 8'($urandom()),
                   8'($urandom()), 1'($urandom()));
    sel = $urandom_range(99);
    if (sel < 45) begin
      it.opcode = sarq_pkg::OP_ENQ;
      if ($urandom_range(1)) begin
        it.proto_disc = rr_pd;
        it.msg_kind = mr_type;
      end
      if ($urandom_range(1)) it.payload_len = sarq_pkg::FullBlockLen;
    end else if (sel < 72) begin
      it.opcode = sarq_pkg::OP_SACCH;
    end else if (sel < 97) begin
      it.opcode = sarq_pkg::OP_TCH;
    end else begin
      it.opcode = 2'd3;
    end
    return it;
  endfunction

  // Directed: default fallback, cache, alternation, full queue, TCH misses, unused opcode.
  task automatic test_directed();
    send_item(make_item(sarq_pkg::OP_SACCH, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0));
    send_item(make_item(sarq_pkg::OP_SACCH, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0));
    send_item(make_item(sarq_pkg::OP_TCH, 8'h00, 4'h0, 8'h00, 8'h00, 1'b1));
    send_item(make_item(2'd3, 8'hFF, 4'hF, 8'hFF, 8'hFF, 1'b1));
    send_item(make_item(sarq_pkg::OP_ENQ, 8'hFF, 4'hF, 8'hFF, sarq_pkg::FullBlockLen, 1'b0));
    send_item(make_item(sarq_pkg::OP_ENQ, 8'h00, 4'd6, 8'd21, 8'hFF, 1'b1));
    send_item(make_item(sarq_pkg::OP_ENQ, 8'h5A, 4'h0, 8'h00, 8'h00, 1'b0));
    send_item(make_item(sarq_pkg::OP_SACCH, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0));
    send_item(make_item(sarq_pkg::OP_SACCH, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0));
    send_item(make_item(sarq_pkg::OP_SACCH, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0));
    send_item(make_item(sarq_pkg::OP_TCH, 8'h00, 4'h0, 8'h00, 8'h00, 1'b0));
    // Fill the queue past its depth to see rejects.
    for (int i = 0; i < 18; i++)
      send_item(make_item(sarq_pkg::OP_ENQ, 8'(i * 13), 4'(i), 8'(i),
                          (i % 2) ? sarq_pkg::FullBlockLen : 8'd1, 1'b0));
    drain();
  endtask

  // Long receiver hold-off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_cycles = 0;
    hold_results = 1'b1;
    for (int i = 0; i < 30; i++) send_item(rand_item());
    drain();
  endtask

  // Random items in phases, one register setting per phase.
  task automatic test_random_phase(logic [3:0] pd, logic [7:0] mt, int n, bit quiet);
    write_reg(sarq_pkg::CFG_RR_PD, {4'b0, pd});
    write_reg(sarq_pkg::CFG_MR_TYPE, mt);
    steady = quiet;
    for (int i = 0; i < n; i++) send_item(rand_item());
    steady = 1'b0;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    errors = 0;
    results_seen = 0;
    items_sent = 0;
    fallbacks_seen = 0;
    rejects_seen = 0;
    cycle_count = 0;
    steady = 1'b0;
    hold_results = 1'b0;
    hold_cycles = 0;
    q_cnt = 0;
    prev_report = 1'b0;
    cache_valid = 1'b0;
    reuse = '0;
    rr_pd = 4'd6;
    mr_type = 8'd21;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_random_phase(4'd6, 8'd21, 500, 1'b0);
    test_random_phase(4'd0, 8'd0, 400, 1'b1);
    test_random_phase(4'd15, 8'd255, 450, 1'b0);
    test_random_phase(4'($urandom()), 8'($urandom()), 450, 1'b0);
    drain();

    $display("covered %0d items, %0d results, %0d fallbacks, %0d full-queue rejects",
             items_sent, results_seen, fallbacks_seen, rejects_seen);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
